/* hw/rtl/ilp_pkg.sv */
// Package for the integer literal parser: compare state type, limits and
// the digit table of the largest positive 32-bit value. No dependencies.
package ilp_pkg;

   typedef enum logic [1:0] {
      CMP_EQUAL   = 2'd0,
      CMP_LESS    = 2'd1,
      CMP_GREATER = 2'd2
   } cmp_type;

   localparam int unsigned ACC_W      = 32;
   localparam int unsigned CNT_W      = 4;
   localparam int unsigned HEX_DIGITS = 8;
   localparam int unsigned DEC_DIGITS = 10;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_NINE  = 8'h39;
   localparam logic [7:0]  CHAR_UA    = 8'h41;
   localparam logic [7:0]  CHAR_UF    = 8'h46;
   localparam logic [7:0]  CHAR_LA    = 8'h61;
   localparam logic [7:0]  CHAR_LF    = 8'h66;

   // ASCII digits of "2147483647"
   function automatic logic [7:0] int_max_digit(input logic [CNT_W-1:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h32;
         4'd1:    c = 8'h31;
         4'd2:    c = 8'h34;
         4'd3:    c = 8'h37;
         4'd4:    c = 8'h34;
         4'd5:    c = 8'h38;
         4'd6:    c = 8'h33;
         4'd7:    c = 8'h36;
         4'd8:    c = 8'h34;
         4'd9:    c = 8'h37;
         default: c = 8'h30;
      endcase
      return c;
   endfunction

endpackage

/* hw/rtl/ilp_req_if.sv */
// Request channel: one literal character with hex flag and last marker.
// Depends on nothing.
interface ilp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_hex;
   logic       last;

   modport source (output valid, output ch, output is_hex, output last, input ready);
   modport sink   (input valid, input ch, input is_hex, input last, output ready);
endinterface

/* hw/rtl/ilp_rsp_if.sv */
// Response channel: parsed value with range and bad character flags.
// Depends on nothing.
interface ilp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        out_of_range;
   logic        bad_char;

   modport source (output valid, output value, output out_of_range, output bad_char,
                   input ready);
   modport sink   (input valid, input value, input out_of_range, input bad_char,
                   output ready);
endinterface

/* hw/rtl/int_literal_parse_range_check_top.sv */
// Integer literal parser with 32-bit range check, one character per request.
// Latency: the response is valid the cycle after the request carrying last.
// Throughput: one request per cycle unless a response waits; the single response
// register holds new requests off while the previous response is not taken.
// Reset: synchronous, clears the literal state and the response valid.
// Depends on ilp_pkg, ilp_req_if, ilp_rsp_if.
module int_literal_parse_range_check_top (
   input  logic        clock,
   input  logic        reset,
   ilp_req_if.sink     req_if,
   ilp_rsp_if.source   rsp_if
);

   logic [ilp_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [ilp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   ilp_pkg::cmp_type          cmp_ff, cmp_in;
   logic                      bad_ff, bad_in;
   logic                      hex_ff, hex_in;
   logic                      in_lit_ff, in_lit_in;

   logic [ilp_pkg::ACC_W-1:0] value_ff, value_in;
   logic                      oor_ff, oor_in;
   logic                      badc_ff, badc_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      accept;
   logic                      first;
   logic                      hex;
   logic [ilp_pkg::ACC_W-1:0] acc_cur;
   logic [ilp_pkg::CNT_W-1:0] cnt_cur;
   ilp_pkg::cmp_type          cmp_cur;
   logic                      bad_cur;
   logic                      is_dec, is_upper, is_lower, ok;
   logic [3:0]                dig;
   logic [7:0]                dig_chr, ref_chr;
   logic                      skip;
   logic [ilp_pkg::ACC_W-1:0] acc_nx;
   logic [ilp_pkg::CNT_W-1:0] cnt_nx;
   ilp_pkg::cmp_type          cmp_nx;
   logic                      bad_nx;
   logic                      oor_nx;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign first   = !in_lit_ff;
   assign hex     = first ? req_if.is_hex : hex_ff;
   assign acc_cur = first ? '0 : acc_ff;
   assign cnt_cur = first ? '0 : cnt_ff;
   assign cmp_cur = first ? ilp_pkg::CMP_EQUAL : cmp_ff;
   assign bad_cur = first ? 1'b0 : bad_ff;

   assign is_dec   = (req_if.ch >= ilp_pkg::CHAR_ZERO) && (req_if.ch <= ilp_pkg::CHAR_NINE);
   assign is_upper = hex && (req_if.ch >= ilp_pkg::CHAR_UA) && (req_if.ch <= ilp_pkg::CHAR_UF);
   assign is_lower = hex && (req_if.ch >= ilp_pkg::CHAR_LA) && (req_if.ch <= ilp_pkg::CHAR_LF);
   assign ok       = is_dec || is_upper || is_lower;

   always_comb begin
      if (is_dec) begin
         dig = req_if.ch[3:0];
      end else if (is_upper || is_lower) begin
         dig = req_if.ch[3:0] + 4'd9;
      end else begin
         dig = 4'd0;
      end
   end

   assign dig_chr = {4'd0, dig} + ilp_pkg::CHAR_ZERO;
   assign ref_chr = ilp_pkg::int_max_digit(cnt_cur);
   assign skip    = (cnt_cur == '0) && (req_if.ch == ilp_pkg::CHAR_ZERO);
   assign bad_nx  = bad_cur || !ok;

   always_comb begin
      acc_nx = acc_cur;
      cnt_nx = cnt_cur;
      cmp_nx = cmp_cur;
      if (!skip) begin
         if (hex) begin
            acc_nx = {acc_cur[ilp_pkg::ACC_W-5:0], dig};
         end else begin
            acc_nx = {acc_cur[ilp_pkg::ACC_W-4:0], 3'd0} + {acc_cur[ilp_pkg::ACC_W-2:0], 1'b0}
                     + {{(ilp_pkg::ACC_W-4){1'b0}}, dig};
         end
         if (cnt_cur != '1) begin
            cnt_nx = cnt_cur + 1'b1;
         end
         if ((cnt_cur < ilp_pkg::CNT_W'(ilp_pkg::DEC_DIGITS)) &&
             (cmp_cur == ilp_pkg::CMP_EQUAL)) begin
            if (dig_chr < ref_chr) begin
               cmp_nx = ilp_pkg::CMP_LESS;
            end else if (dig_chr > ref_chr) begin
               cmp_nx = ilp_pkg::CMP_GREATER;
            end
         end
      end
   end

   always_comb begin
      if (hex) begin
         oor_nx = cnt_nx > ilp_pkg::CNT_W'(ilp_pkg::HEX_DIGITS);
      end else begin
         oor_nx = (cnt_nx > ilp_pkg::CNT_W'(ilp_pkg::DEC_DIGITS)) ||
                  ((cnt_nx == ilp_pkg::CNT_W'(ilp_pkg::DEC_DIGITS)) &&
                   (cmp_nx == ilp_pkg::CMP_GREATER));
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      cmp_in       = cmp_ff;
      bad_in       = bad_ff;
      hex_in       = hex_ff;
      in_lit_in    = in_lit_ff;
      value_in     = value_ff;
      oor_in       = oor_ff;
      badc_in      = badc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (accept) begin
         acc_in = acc_nx;
         cnt_in = cnt_nx;
         cmp_in = cmp_nx;
         bad_in = bad_nx;
         hex_in = hex;
         if (req_if.last) begin
            in_lit_in    = 1'b0;
            value_in     = acc_nx;
            oor_in       = oor_nx;
            badc_in      = bad_nx;
            rsp_valid_in = 1'b1;
         end else begin
            in_lit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         cmp_ff       <= ilp_pkg::CMP_EQUAL;
         bad_ff       <= 1'b0;
         hex_ff       <= 1'b0;
         in_lit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         cmp_ff       <= cmp_in;
         bad_ff       <= bad_in;
         hex_ff       <= hex_in;
         in_lit_ff    <= in_lit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      oor_ff   <= oor_in;
      badc_ff  <= badc_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.value        = value_ff;
   assign rsp_if.out_of_range = oor_ff;
   assign rsp_if.bad_char     = badc_ff;

endmodule

/* tb/int_literal_parse_range_check_top_tb.sv */
// Testbench for int_literal_parse_range_check_top: sends literals one character per request,
// predicts value/range/bad-char per literal in a scoreboard class and checks every response.
// Depends on ilp_pkg, ilp_req_if, ilp_rsp_if and the top level RTL.
module int_literal_parse_range_check_top_tb;

   localparam int          TOTAL_REQUESTS = 1800;
   localparam int          QUIET_FROM     = 1500;
   localparam int          LONG_HOLD      = 300;
   localparam int          STALL_LIMIT    = 3000;
   localparam logic [7:0]  ASCII_0        = "0";
   localparam logic [7:0]  ASCII_9        = "9";
   localparam logic [7:0]  ASCII_UA       = "A";
   localparam logic [7:0]  ASCII_UF       = "F";
   localparam logic [7:0]  ASCII_LA       = "a";
   localparam logic [7:0]  ASCII_LF       = "f";
   localparam logic [79:0] INT_MAX_TEXT   = "2147483647";

   typedef struct packed {
      logic [31:0] value;
      logic        out_of_range;
      logic        bad_char;
   } parsed_literal_type;

   class literal_scoreboard_type;
      logic [31:0]        acc;
      logic [3:0]         sig_count;
      ilp_pkg::cmp_type   cmp;
      logic               bad_seen;
      logic               hex_mode;
      logic               in_literal;
      parsed_literal_type expected[$];
      int                 failures;

      function new();
         in_literal = 1'b0;
         failures = 0;
      endfunction

      function void note_request(input logic [7:0] c, input logic hex, input logic last);
         logic [3:0]         d;
         logic               ok;
         logic [7:0]         lim;
         parsed_literal_type r;
         if (!in_literal) begin
            acc = '0;
            sig_count = '0;
            cmp = ilp_pkg::CMP_EQUAL;
            bad_seen = 1'b0;
            hex_mode = hex;
            in_literal = 1'b1;
         end
         ok = 1'b1;
         d = '0;
         if (c >= ASCII_0 && c <= ASCII_9) d = 4'(c - ASCII_0);
         else if (hex_mode && c >= ASCII_UA && c <= ASCII_UF) d = 4'(c - ASCII_UA + 8'd10);
         else if (hex_mode && c >= ASCII_LA && c <= ASCII_LF) d = 4'(c - ASCII_LA + 8'd10);
         else ok = 1'b0;
         if (!ok) bad_seen = 1'b1;
         if (!(sig_count == 0 && c == ASCII_0)) begin
            if (sig_count < ilp_pkg::DEC_DIGITS && cmp == ilp_pkg::CMP_EQUAL) begin
               lim = INT_MAX_TEXT[79 - 8*sig_count -: 8];
               if (ASCII_0 + d < lim) cmp = ilp_pkg::CMP_LESS;
               else if (ASCII_0 + d > lim) cmp = ilp_pkg::CMP_GREATER;
            end
            acc = acc * (hex_mode ? 32'd16 : 32'd10) + 32'(d);
            if (sig_count != 4'd15) sig_count++;
         end
         if (last) begin
            r.value = acc;
            if (hex_mode) r.out_of_range = sig_count > ilp_pkg::HEX_DIGITS;
            else r.out_of_range = sig_count > ilp_pkg::DEC_DIGITS ||
                                  (sig_count == ilp_pkg::DEC_DIGITS &&
                                   cmp == ilp_pkg::CMP_GREATER);
            r.bad_char = bad_seen;
            expected.push_back(r);
            in_literal = 1'b0;
         end
      endfunction

      function void check_response(input logic [31:0] value, input logic oor, input logic bad);
         parsed_literal_type e;
         if (expected.size() == 0) begin
            $error("unexpected response: value %h out_of_range %b bad_char %b", value, oor, bad);
            failures++;
            return;
         end
         e = expected.pop_front();
         if (value !== e.value) begin
            $error("value: expected %h, actual %h", e.value, value);
            failures++;
         end
         if (oor !== e.out_of_range) begin
            $error("out_of_range: expected %b, actual %b", e.out_of_range, oor);
            failures++;
         end
         if (bad !== e.bad_char) begin
            $error("bad_char: expected %b, actual %b", e.bad_char, bad);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ilp_req_if req_if();
   ilp_rsp_if rsp_if();

   int_literal_parse_range_check_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   literal_scoreboard_type sb = new();
   logic [7:0]        literal_text[$];
   int                requests_sent = 0;
   int                hold_requests = 0;
   bit                idling_on = 1'b0;
   int                stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response(rsp_if.value, rsp_if.out_of_range, rsp_if.bad_char);
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // response side: random stalls plus the long hold-offs asked for by the stimulus
   initial begin
      int hold_left;
      int burst_left;
      int holds_done;
      hold_left = 0;
      burst_left = 0;
      holds_done = 0;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready = 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_if.ready = 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(1, 13) - 1;
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // called and returns at a falling edge
   task automatic send_request(input logic [7:0] c, input logic hex, input logic last);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.ch = c;
      req_if.is_hex = hex;
      req_if.last = last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(c, hex, last);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_literal(input bit hex);
      int i;
      for (i = 0; i < literal_text.size(); i++)
         send_request(literal_text[i], (i == 0) ? hex : 1'($urandom_range(0, 1)),
                      i == literal_text.size() - 1);
   endtask

   task automatic send_text(input string s, input bit hex);
      int i;
      literal_text.delete();
      for (i = 0; i < s.len(); i++) literal_text.push_back(s[i]);
      send_literal(hex);
   endtask

   function automatic logic [7:0] digit_char(input int unsigned v, input bit upper);
      if (v < 10) return 8'(ASCII_0 + v);
      return 8'((upper ? ASCII_UA : ASCII_LA) + v - 10);
   endfunction

   task automatic push_digits(input int len, input bit hex);
      repeat (len)
         literal_text.push_back(digit_char($urandom_range(0, hex ? 15 : 9),
                                          1'($urandom_range(0, 1))));
   endtask

   initial begin
      int          kind;
      int          len;
      int          pos;
      bit          hex;
      longint      v;
      string       s;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.ch = '0;
      req_if.is_hex = 1'b0;
      req_if.last = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      idling_on = 1'b1;
      send_text("0", 1'b0);
      send_text("00", 1'b0);
      send_text("2147483648", 1'b0);
      send_text("aF", 1'b1);
      send_text("9G", 1'b1);
      send_text("7b", 1'b0);
      literal_text.delete();
      literal_text.push_back(8'h00);
      literal_text.push_back(8'hFF);
      send_literal(1'b0);
      send_text("100000000", 1'b1);

      while (requests_sent < TOTAL_REQUESTS) begin
         if (requests_sent >= 600 && hold_requests == 0) hold_requests = 1;
         if (requests_sent >= 1200 && hold_requests == 1) hold_requests = 2;
         if (requests_sent >= QUIET_FROM) idling_on = 1'b0;
         kind = $urandom_range(0, 99);
         hex = 1'($urandom_range(0, 1));
         literal_text.delete();
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) literal_text.push_back(ASCII_0);
         if (kind < 20) begin
            // decimal values around the signed and unsigned 32-bit limits
            hex = 1'b0;
            v = ($urandom_range(0, 2) == 0) ? 64'd4294967200 : 64'd2147483600;
            v = v + $urandom_range(0, 100);
            s = $sformatf("%0d", v);
            for (pos = 0; pos < s.len(); pos++) literal_text.push_back(s[pos]);
         end else if (kind < 70) begin
            if ($urandom_range(0, 2) == 0)
               len = hex ? $urandom_range(7, 10) : $urandom_range(9, 11);
            else
               len = $urandom_range(1, 12);
            push_digits(len, hex);
         end else if (kind < 80) begin
            push_digits($urandom_range(13, 18), hex);
         end else if (kind < 90) begin
            push_digits($urandom_range(1, 10), hex);
            pos = $urandom_range(0, literal_text.size() - 1);
            if (!hex && $urandom_range(0, 1) == 0)
               literal_text[pos] = digit_char($urandom_range(10, 15), 1'($urandom_range(0, 1)));
            else
               literal_text[pos] = 8'($urandom_range(0, 255));
         end else begin
            repeat ($urandom_range(1, 5)) literal_text.push_back(8'($urandom_range(0, 255)));
         end
         send_literal(hex);
      end
      req_if.valid = 1'b0;

      while (sb.expected.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (sb.expected.size() != 0) begin
         $error("%0d literal results never arrived", sb.expected.size());
         sb.failures++;
      end
      if (sb.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/ilp_pkg.sv
hw/rtl/ilp_req_if.sv
hw/rtl/ilp_rsp_if.sv
hw/rtl/int_literal_parse_range_check_top.sv
tb/int_literal_parse_range_check_top_tb.sv
